// ===== rtl/tst_pkg.sv =====
// ---------------------------------------------------------------------------
// tst_pkg: shared types and codes for the thread slot table
// request codes, status codes, payload widths and the sequencer state type
// ---------------------------------------------------------------------------
package tst_pkg;

   localparam int TID_W    = 31;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SETK   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_RANGE  = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_RDWAIT,
      ST_SCAN
   } state_type;

endpackage

// ===== rtl/tst_ram.sv =====
// ---------------------------------------------------------------------------
// tst_ram: generic single-port-write ram with registered read
// one write and one read address per cycle, no reset on contents
// ---------------------------------------------------------------------------
module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/thread_slot_table.sv =====
// ---------------------------------------------------------------------------
// thread_slot_table: thread slot allocator with lifo free list
// grants slots on insert (recently freed first, else next unused at the
// high-water mark), frees on delete, reads, finds by thread id, sets kernel
// ids and checks indices against the high-water mark
// ---------------------------------------------------------------------------
//
//   channel   ports                         transfer when
//   -------   ---------------------------   -------------------------------
//   request   req_type req_thread_id        start high and busy low
//             req_slot_index req_kernel_tid
//   response  rsp_status rsp_result_slot    rsp_valid high (one cycle)
//             rsp_result_tid rsp_result_ktid
//             rsp_in_range
//
// - one request at a time: busy stays high from the transfer until the
//   response strobe, and drops in the strobe cycle
// - range check, unused codes, set kernel id, deletes, inserts at the mark
//   or into a full table, and errors of delete, read and set kernel id:
//   answered from the decode state; inserts that pop the free stack and
//   successful reads: from the pop or read-wait state after the ram read
// - find scans slots one per cycle through the shared ram read port; a hit
//   answers as its entry compares, a miss after all slots below the mark
// - reset (synchronous) empties the table: free stack and high-water mark
//   go to zero and all occupied bits clear; ram contents are not cleared
// - the receiver cannot stall: each response is shown for exactly one cycle
// ---------------------------------------------------------------------------
module thread_slot_table
   import tst_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic [REQ_W-1:0]          req_type,
   input  logic [TID_W-1:0]          req_thread_id,
   input  logic [$clog2(SLOTS)-1:0]  req_slot_index,
   input  logic [TID_W-1:0]          req_kernel_tid,
   // response channel
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [$clog2(SLOTS)-1:0]  rsp_result_slot,
   output logic [TID_W-1:0]          rsp_result_tid,
   output logic [TID_W-1:0]          rsp_result_ktid,
   output logic                      rsp_in_range
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   // sequencer state
   state_type state_ff, state_in;

   // latched request
   logic [REQ_W-1:0] req_code_ff;
   logic [TID_W-1:0] tid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [TID_W-1:0] ktid_ff;

   // table bookkeeping
   logic [SLOTS-1:0] occupied_ff;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] high_water_ff, high_water_in;

   // find scan pointer and the entry whose ram data is arriving
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   // response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [TID_W-1:0]    rsp_tid_ff, rsp_tid_in;
   logic [TID_W-1:0]    rsp_ktid_ff, rsp_ktid_in;
   logic                rsp_inr_ff, rsp_inr_in;

   // ram ports
   logic             tid_we, ktid_we, stk_we;
   logic [IDX_W-1:0] slot_wr_addr, slot_rd_addr;
   logic [TID_W-1:0] ktid_wr_data;
   logic [TID_W-1:0] tid_rd_data, ktid_rd_data;
   logic [IDX_W-1:0] stk_wr_addr, stk_rd_addr;
   logic [IDX_W-1:0] stk_rd_data;

   // occupied bit update
   logic             occ_we, occ_wr_val;
   logic [IDX_W-1:0] occ_wr_addr, occ_rd_addr;
   logic             occ_rd;

   logic [CNT_W-1:0] idx_ext;
   logic             idx_in_range;
   logic             scan_match;

   assign idx_ext      = CNT_W'(idx_ff);
   assign idx_in_range = idx_ext < high_water_ff;
   assign occ_rd       = occupied_ff[occ_rd_addr];
   assign scan_match   = cmp_valid_ff && occ_rd && (tid_rd_data == tid_ff);

   tst_ram #(.WIDTH(TID_W), .DEPTH(SLOTS)) u_tid_ram (
      .clock   (clock),
      .wr_en   (tid_we),
      .wr_addr (slot_wr_addr),
      .wr_data (tid_ff),
      .rd_addr (slot_rd_addr),
      .rd_data (tid_rd_data)
   );

   tst_ram #(.WIDTH(TID_W), .DEPTH(SLOTS)) u_ktid_ram (
      .clock   (clock),
      .wr_en   (ktid_we),
      .wr_addr (slot_wr_addr),
      .wr_data (ktid_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (ktid_rd_data)
   );

   // lifo free stack, top entry at free_count - 1
   tst_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (idx_ff),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occupied_ff   <= '0;
         free_count_ff <= '0;
         high_water_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         high_water_ff <= high_water_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (occ_we) begin
            occupied_ff[occ_wr_addr] <= occ_wr_val;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_code_ff <= req_type;
         tid_ff      <= req_thread_id;
         idx_ff      <= req_slot_index;
         ktid_ff     <= req_kernel_tid;
      end
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tid_ff    <= rsp_tid_in;
      rsp_ktid_ff   <= rsp_ktid_in;
      rsp_inr_ff    <= rsp_inr_in;
   end

   always_comb begin
      state_in      = state_ff;
      free_count_in = free_count_ff;
      high_water_in = high_water_ff;
      scan_in       = scan_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tid_in    = rsp_tid_ff;
      rsp_ktid_in   = rsp_ktid_ff;
      rsp_inr_in    = rsp_inr_ff;

      tid_we       = 1'b0;
      ktid_we      = 1'b0;
      stk_we       = 1'b0;
      slot_wr_addr = idx_ff;
      slot_rd_addr = idx_ff;
      ktid_wr_data = '0;
      stk_wr_addr  = free_count_ff[IDX_W-1:0];
      stk_rd_addr  = IDX_W'(free_count_ff - 1'b1);

      occ_we      = 1'b0;
      occ_wr_val  = 1'b0;
      occ_wr_addr = idx_ff;
      occ_rd_addr = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            // most outcomes are known here; default response is ok, all zero
            rsp_status_in = STAT_OK;
            rsp_slot_in   = '0;
            rsp_tid_in    = '0;
            rsp_ktid_in   = '0;
            rsp_inr_in    = 1'b0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
            case (req_code_ff)
               REQ_INSERT: begin
                  if (free_count_ff != '0) begin
                     // stack top read issued now, slot granted next cycle
                     rsp_valid_in = 1'b0;
                     state_in     = ST_POP;
                  end else if (high_water_ff < SLOTS_CNT) begin
                     slot_wr_addr  = high_water_ff[IDX_W-1:0];
                     tid_we        = 1'b1;
                     ktid_we       = 1'b1;
                     occ_we        = 1'b1;
                     occ_wr_val    = 1'b1;
                     occ_wr_addr   = high_water_ff[IDX_W-1:0];
                     high_water_in = high_water_ff + 1'b1;
                     rsp_slot_in   = high_water_ff[IDX_W-1:0];
                  end else begin
                     rsp_status_in = STAT_FULL;
                  end
               end
               REQ_DELETE, REQ_READ, REQ_SETK: begin
                  if (!idx_in_range) begin
                     rsp_status_in = STAT_RANGE;
                  end else if (!occ_rd) begin
                     rsp_status_in = STAT_EMPTY;
                  end else if (req_code_ff == REQ_DELETE) begin
                     occ_we = 1'b1;
                     if (free_count_ff < SLOTS_CNT) begin
                        stk_we        = 1'b1;
                        free_count_in = free_count_ff + 1'b1;
                     end
                  end else if (req_code_ff == REQ_READ) begin
                     // ram read of the slot issued now
                     rsp_valid_in = 1'b0;
                     state_in     = ST_RDWAIT;
                  end else begin
                     ktid_we      = 1'b1;
                     ktid_wr_data = ktid_ff;
                  end
               end
               REQ_FIND: begin
                  rsp_valid_in = 1'b0;
                  scan_in      = '0;
                  cmp_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end
               REQ_RANGE: begin
                  rsp_inr_in = idx_in_range;
               end
               default: begin
                  // unused codes answer ok with zero fields
               end
            endcase
         end

         ST_POP: begin
            slot_wr_addr  = stk_rd_data;
            tid_we        = 1'b1;
            ktid_we       = 1'b1;
            occ_we        = 1'b1;
            occ_wr_val    = 1'b1;
            occ_wr_addr   = stk_rd_data;
            free_count_in = free_count_ff - 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in   = stk_rd_data;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_RDWAIT: begin
            rsp_status_in = STAT_OK;
            rsp_tid_in    = tid_rd_data;
            rsp_ktid_in   = ktid_rd_data;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_SCAN: begin
            // one ram read per cycle; compare the entry read last cycle
            occ_rd_addr = cmp_idx_ff;
            if (scan_match) begin
               rsp_status_in = STAT_OK;
               rsp_slot_in   = cmp_idx_ff;
               rsp_tid_in    = tid_rd_data;
               rsp_ktid_in   = ktid_rd_data;
               rsp_valid_in  = 1'b1;
               cmp_valid_in  = 1'b0;
               state_in      = ST_IDLE;
            end else if (scan_ff < high_water_ff) begin
               slot_rd_addr = scan_ff[IDX_W-1:0];
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + 1'b1;
            end else if (cmp_valid_ff) begin
               // last entry missed, clear the compare flag before answering
               cmp_valid_in = 1'b0;
            end else begin
               rsp_status_in = STAT_EMPTY;
               rsp_slot_in   = '0;
               rsp_tid_in    = '0;
               rsp_ktid_in   = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
            rsp_inr_in = 1'b0;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_result_tid  = rsp_tid_ff;
   assign rsp_result_ktid = rsp_ktid_ff;
   assign rsp_in_range    = rsp_inr_ff;

endmodule
